@@ src/deadline_job_sequencer_core_macros.svh @@
// assertion macros for the job sequencer checker
`ifndef DEADLINE_JOB_SEQUENCER_CORE_MACROS_SVH
`define DEADLINE_JOB_SEQUENCER_CORE_MACROS_SVH
`define DJS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define DJS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

@@ src/djs_pkg.sv @@
package djs_pkg;
	localparam int unsigned DEADLINE_W = 8;
	localparam int unsigned PROFIT_W = 16;
	localparam int unsigned JOBNUM_W = 5;
	localparam int unsigned TOTAL_W = 21;
	localparam int unsigned SUM_W = 22;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	typedef struct packed {
		logic [DEADLINE_W-1:0] deadline;
		logic [PROFIT_W-1:0] profit;
		logic last_job;
	} job_t;

	typedef struct packed {
		logic [JOBNUM_W-1:0] job_number;
		logic [TOTAL_W-1:0] total_profit;
		logic dropped_jobs;
		logic last_result;
	} res_t;
endpackage

@@ src/deadline_job_sequencer_core.sv @@
// a set is scheduled once its last job is taken from the queue
// throughput: one job accepted per cycle while the queue of four ahead of the scheduler is not full
// scheduling is sequential: profit scan over the job store then a priority slot search
// reset: asynchronous active low, clears counts, slot mask, sum and queue; stores undefined
module deadline_job_sequencer_core
	import djs_pkg::*;
#(
	parameter int unsigned MAX_JOBS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] deadline,
	input logic [15:0] profit,
	input logic last_job,
	output logic out_valid,
	input logic out_stall,
	output logic [4:0] job_number,
	output logic [20:0] total_profit,
	output logic dropped_jobs,
	output logic last_result
);
	job_t in_job, q_job;
	logic q_valid, q_take;
	res_t res;

	assign in_job = '{deadline: deadline, profit: profit, last_job: last_job};

	djs_fifo #(.DEPTH(4)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(in_valid), .wr_stall(in_stall), .wr_data(in_job),
		.rd_valid(q_valid), .rd_take(q_take), .rd_data(q_job)
	);

	djs_sched #(.MAX_JOBS(MAX_JOBS)) u_sched (
		.clk(clk), .arst_n(arst_n),
		.job_valid(q_valid), .job_take(q_take), .job(q_job),
		.res_valid(out_valid), .res_stall(out_stall), .res(res)
	);

	assign job_number = res.job_number;
	assign total_profit = res.total_profit;
	assign dropped_jobs = res.dropped_jobs;
	assign last_result = res.last_result;
endmodule

@@ src/djs_fifo.sv @@
module djs_fifo
	import djs_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	output logic wr_stall,
	input job_t wr_data,
	output logic rd_valid,
	input logic rd_take,
	output job_t rd_data
);
	localparam int unsigned AW = $clog2(DEPTH);
	job_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic wr, rd;

	assign wr_stall = (cnt_q == (AW+1)'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && !wr_stall;
	assign rd = rd_take && rd_valid;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end
endmodule

@@ src/djs_sched.sv @@
module djs_sched
	import djs_pkg::*;
#(
	parameter int unsigned MAX_JOBS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	output logic job_take,
	input job_t job,
	output logic res_valid,
	input logic res_stall,
	output res_t res
);
	localparam int unsigned IW = $clog2(MAX_JOBS);
	localparam int unsigned CW = $clog2(MAX_JOBS+1);
	localparam int unsigned RW = 6;
	localparam int unsigned MAX_RES = 32;

	typedef enum logic [2:0] {LOAD, PICK_INIT, PICK, SLOT, EMIT_WAIT} st_t;
	st_t st_q;

	logic [DEADLINE_W-1:0] dl_mem_q [MAX_JOBS];
	logic [PROFIT_W-1:0] pr_mem_q [MAX_JOBS];
	logic [MAX_JOBS-1:0] done_q;
	logic [MAX_JOBS-1:0] mask_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] scan_q;
	logic [CW-1:0] round_q;
	logic [IW-1:0] best_q;
	logic found_q;
	logic [PROFIT_W-1:0] best_pr_q;
	logic [SUM_W-1:0] sum_q;
	logic ovf_q;
	logic [RW-1:0] nres_q;
	logic [IW-1:0] pend_idx_q;
	logic pend_q;
	logic [DEADLINE_W-1:0] rd_dl;
	logic [PROFIT_W-1:0] rd_pr;
	logic [IW-1:0] scan_idx;
	logic [CW-1:0] lim;
	logic [MAX_JOBS-1:0] free_m;
	logic slot_ok;
	logic [IW-1:0] slot_idx;
	logic out_free;
	logic load_res;
	logic [SUM_W-1:0] next_sum;

	assign scan_idx = scan_q[IW-1:0];
	assign rd_pr = pr_mem_q[scan_idx];
	assign rd_dl = dl_mem_q[best_q];
	assign out_free = !res_valid || !res_stall;
	assign job_take = (st_q == LOAD) && job_valid;
	assign load_res = out_free && pend_q &&
		((st_q == SLOT && slot_ok && nres_q != RW'(MAX_RES)) || st_q == EMIT_WAIT);

	always_comb begin
		if (CW'(rd_dl) > CW'(MAX_JOBS) || rd_dl > DEADLINE_W'(MAX_JOBS)) begin
			lim = CW'(MAX_JOBS);
		end else begin
			lim = CW'(rd_dl);
		end
		slot_ok = 1'b0;
		slot_idx = '0;
		for (int s = 0; s < MAX_JOBS; s++) begin
			free_m[s] = !mask_q[s] && (CW'(s) < lim);
			if (free_m[s]) begin
				slot_ok = 1'b1;
				slot_idx = IW'(s);
			end
		end
	end

	assign next_sum = sum_q + SUM_W'(pr_mem_q[best_q]);

	always_ff @(posedge clk) begin
		if (job_take && count_q < CW'(MAX_JOBS)) begin
			dl_mem_q[count_q[IW-1:0]] <= job.deadline;
			pr_mem_q[count_q[IW-1:0]] <= job.profit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= LOAD;
			done_q <= '0;
			mask_q <= '0;
			count_q <= '0;
			scan_q <= '0;
			round_q <= '0;
			best_q <= '0;
			found_q <= 1'b0;
			best_pr_q <= '0;
			sum_q <= '0;
			ovf_q <= 1'b0;
			nres_q <= '0;
			pend_idx_q <= '0;
			pend_q <= 1'b0;
			res_valid <= 1'b0;
			res <= '0;
		end else begin
			if (res_valid && !res_stall && !load_res) begin
				res_valid <= 1'b0;
			end
			unique case (st_q)
				LOAD: begin
					if (job_take) begin
						if (count_q < CW'(MAX_JOBS)) begin
							count_q <= count_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (job.last_job) begin
							round_q <= '0;
							st_q <= PICK_INIT;
						end
					end
				end
				PICK_INIT: begin
					scan_q <= '0;
					found_q <= 1'b0;
					if (round_q == count_q || round_q == CW'(MAX_JOBS)) begin
						st_q <= EMIT_WAIT;
					end else begin
						st_q <= PICK;
					end
				end
				PICK: begin
					if (scan_q == count_q) begin
						st_q <= found_q ? SLOT : EMIT_WAIT;
					end else begin
						if (!done_q[scan_idx] && (!found_q || rd_pr > best_pr_q)) begin
							best_q <= scan_idx;
							best_pr_q <= rd_pr;
							found_q <= 1'b1;
						end
						scan_q <= scan_q + 1'b1;
					end
				end
				SLOT: begin
					if (!slot_ok || !pend_q || out_free) begin
						done_q[best_q] <= 1'b1;
						round_q <= round_q + 1'b1;
						st_q <= PICK_INIT;
						if (slot_ok) begin
							mask_q[slot_idx] <= 1'b1;
							sum_q <= next_sum;
							if (nres_q != RW'(MAX_RES)) begin
								if (pend_q) begin
									res_valid <= 1'b1;
									res.job_number <= JOBNUM_W'(pend_idx_q);
									res.total_profit <= '0;
									res.dropped_jobs <= ovf_q;
									res.last_result <= 1'b0;
								end
								pend_q <= 1'b1;
								pend_idx_q <= best_q;
								nres_q <= nres_q + 1'b1;
							end
						end
					end
				end
				EMIT_WAIT: begin
					if (!pend_q || out_free) begin
						if (pend_q) begin
							res_valid <= 1'b1;
							res.job_number <= JOBNUM_W'(pend_idx_q);
							res.total_profit <= (sum_q > SUM_W'(TOTAL_MAX)) ?
								TOTAL_MAX : sum_q[TOTAL_W-1:0];
							res.dropped_jobs <= ovf_q;
							res.last_result <= 1'b1;
						end
						pend_q <= 1'b0;
						nres_q <= '0;
						done_q <= '0;
						mask_q <= '0;
						count_q <= '0;
						sum_q <= '0;
						ovf_q <= 1'b0;
						st_q <= LOAD;
					end
				end
				default: st_q <= LOAD;
			endcase
		end
	end
endmodule

@@ src/djs_checker.sv @@
`include "deadline_job_sequencer_core_macros.svh"
module djs_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic [4:0] job_number,
	input logic [20:0] total_profit,
	input logic last_result
);
	`DJS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(job_number))
	`DJS_ASSERT_IMPL(a_tot_zero, clk, arst_n, out_valid && !last_result, total_profit == '0)
	`DJS_ASSERT_NEXT(a_last_hold, clk, arst_n, out_valid && out_stall, $stable(last_result))
endmodule

bind deadline_job_sequencer_core djs_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall),
	.job_number(job_number), .total_profit(total_profit), .last_result(last_result)
);

@@ verif/djs_checker.sv @@
`timescale 1ns / 100ps
module djs_scoreboard
	import djs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic [7:0] deadline,
	input logic [15:0] profit,
	input logic last_job,
	input logic out_valid,
	input logic out_stall,
	input logic [4:0] job_number,
	input logic [20:0] total_profit,
	input logic dropped_jobs,
	input logic last_result,
	output int fail_count,
	output int pending
);
	localparam int unsigned CAP = 32;

	logic [DEADLINE_W-1:0] dl_store [CAP];
	logic [PROFIT_W-1:0] pr_store [CAP];
	int held;
	bit overflow;
	res_t schedule_q [$];

	assign pending = schedule_q.size();

	// greedy pick by profit, latest free slot at or before the clamped deadline
	function automatic void schedule_set();
		bit [CAP-1:0] done;
		bit [CAP-1:0] taken;
		int picked [CAP];
		int npicked;
		int best;
		int s;
		logic [SUM_W-1:0] sum;
		res_t r;
		done = '0;
		taken = '0;
		sum = '0;
		npicked = 0;
		for (int k = 0; k < held; k++) begin
			best = -1;
			for (int i = 0; i < held; i++) begin
				if (!done[i] && (best < 0 || pr_store[i] > pr_store[best]))
					best = i;
			end
			done[best] = 1'b1;
			s = (dl_store[best] > CAP) ? CAP : int'(dl_store[best]);
			while (s > 0 && taken[s-1])
				s--;
			if (s > 0) begin
				taken[s-1] = 1'b1;
				sum += pr_store[best];
				picked[npicked] = best;
				npicked++;
			end
		end
		for (int k = 0; k < npicked; k++) begin
			r.job_number = JOBNUM_W'(picked[k]);
			r.last_result = (k == npicked - 1);
			r.total_profit = !r.last_result ? '0 :
				(sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
			r.dropped_jobs = overflow;
			schedule_q = {schedule_q, r};
		end
		held = 0;
		overflow = 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t e;
		if (!arst_n) begin
			held = 0;
			overflow = 1'b0;
			fail_count = 0;
			schedule_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (schedule_q.size() == 0) begin
					$error("unexpected result transaction, job_number %0d", job_number);
					fail_count++;
				end else begin
					e = schedule_q.pop_front();
					if (job_number !== e.job_number) begin
						$error("job_number: expected %0d, got %0d", e.job_number, job_number);
						fail_count++;
					end
					if (total_profit !== e.total_profit) begin
						$error("total_profit: expected %0d, got %0d", e.total_profit,
							total_profit);
						fail_count++;
					end
					if (dropped_jobs !== e.dropped_jobs) begin
						$error("dropped_jobs: expected %0d, got %0d", e.dropped_jobs,
							dropped_jobs);
						fail_count++;
					end
					if (last_result !== e.last_result) begin
						$error("last_result: expected %0d, got %0d", e.last_result,
							last_result);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (held < CAP) begin
					dl_store[held] = deadline;
					pr_store[held] = profit;
					held++;
				end else begin
					overflow = 1'b1;
				end
				if (last_job)
					schedule_set();
			end
		end
	end
endmodule

@@ verif/deadline_job_sequencer_core_tb.sv @@
`timescale 1ns / 100ps
module deadline_job_sequencer_core_tb;

	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] deadline = '0;
	logic [15:0] profit = '0;
	logic last_job = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [4:0] job_number;
	logic [20:0] total_profit;
	logic dropped_jobs;
	logic last_result;
	int fail_count;
	int pending;
	int jobs_sent = 0;
	int idle_cycles = 0;
	int stall_hold = 0;
	bit quiet = 1'b0;

	deadline_job_sequencer_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.deadline(deadline), .profit(profit), .last_job(last_job),
		.out_valid(out_valid), .out_stall(out_stall),
		.job_number(job_number), .total_profit(total_profit),
		.dropped_jobs(dropped_jobs), .last_result(last_result)
	);

	djs_scoreboard u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.deadline(deadline), .profit(profit), .last_job(last_job),
		.out_valid(out_valid), .out_stall(out_stall),
		.job_number(job_number), .total_profit(total_profit),
		.dropped_jobs(dropped_jobs), .last_result(last_result),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_job(input logic [7:0] d, input logic [15:0] p, input logic l);
		int n;
		n = gap_len();
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		in_valid <= 1'b1;
		deadline <= d;
		profit <= p;
		last_job <= l;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		jobs_sent++;
		@(negedge clk);
	endtask

	task automatic random_set(input int n);
		int dl_max;
		int pr_max;
		int r;
		logic [7:0] d;
		dl_max = $urandom_range(1, 40);
		pr_max = ($urandom_range(0, 3) == 0) ? 3 : 65535;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 9);
			d = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 :
				(r == 2) ? 8'($urandom_range(33, 254)) : 8'($urandom_range(1, dl_max));
			send_job(d, 16'($urandom_range(0, pr_max)), i == n - 1);
		end
	endtask

	always @(negedge clk) begin
		int r;
		if (stall_hold > 0) begin
			stall_hold--;
		end else if (quiet) begin
			out_stall <= 1'b0;
		end else begin
			r = $urandom_range(0, 99);
			out_stall <= (r < 30);
			if (r < 4)
				stall_hold = $urandom_range(10, 50);
			else if (r < 30)
				stall_hold = $urandom_range(0, 3);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		int n;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// directed sets
		send_job(8'd255, 16'hFFFF, 1'b1);
		send_job(8'd0, 16'd500, 1'b0);
		send_job(8'd0, 16'hFFFF, 1'b1);
		send_job(8'd1, 16'd0, 1'b1);
		send_job(8'd2, 16'd7, 1'b0);
		send_job(8'd2, 16'd7, 1'b0);
		send_job(8'd2, 16'd7, 1'b0);
		send_job(8'd1, 16'd9, 1'b1);
		send_job(8'd32, 16'hAAAA, 1'b0);
		send_job(8'd33, 16'h5555, 1'b0);
		send_job(8'd1, 16'h8000, 1'b0);
		send_job(8'd0, 16'd1, 1'b0);
		send_job(8'h80, 16'h0001, 1'b1);
		// full store at maximum profit, then overflow with last job dropped
		for (int i = 0; i < 32; i++)
			send_job(8'd255, 16'hFFFF, 1'b0);
		send_job(8'h7F, 16'h1234, 1'b0);
		send_job(8'd5, 16'h4321, 1'b1);
		// random sets
		while (jobs_sent < 245) begin
			quiet = ($urandom_range(0, 5) == 0);
			n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 8);
			random_set(n);
		end
		quiet = 1'b0;
		in_valid <= 1'b0;
		while (pending > 0)
			@(posedge clk);
		repeat (2000) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+src
src/djs_pkg.sv
src/djs_fifo.sv
src/djs_sched.sv
src/deadline_job_sequencer_core.sv
src/djs_checker.sv
verif/djs_checker.sv
verif/deadline_job_sequencer_core_tb.sv
